// ===== sv/pbtu_pkg.sv =====
// Package for the Poisson-binomial tail update block: sizes, fixed-point
// constants, transaction payload types, sequencer states and helpers.
// Depends on nothing; every other file imports it.
package pbtu_pkg;

    localparam int IMAGES     = 256;
    localparam int MAX_TRIALS = 63;
    localparam int ROW_LEN    = MAX_TRIALS + 1;

    // Width of a trial count and of an entry index within one row.
    localparam int CNT_W   = $clog2(ROW_LEN);
    localparam int IMG_AW  = (IMAGES > 1) ? $clog2(IMAGES) : 1;
    localparam int DIST_AW = $clog2(IMAGES * ROW_LEN);

    localparam int Q_W = 17;
    localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_ADD   = 1'b1;

    // Register index as seen on the configuration port.
    localparam logic REG_MIN_SUCC = 1'b0;

    typedef struct packed {
        logic           opcode;
        logic [7:0]     image;
        logic [16:0]    trial_prob;
    } t_in_item;

    typedef struct packed {
        logic [16:0]    tail_prob;
        logic [5:0]     trials;
        logic           full_res;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_WALK,
        S_DRAIN
    } t_state;

    // Q1.16 addition that saturates at 1.0.
    function automatic logic [Q_W-1:0] sat_add(input logic [Q_W-1:0] a,
                                               input logic [Q_W-1:0] b);
        logic [Q_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, ONE_Q16}) ? ONE_Q16 : s[Q_W-1:0];
    endfunction

endpackage

// ===== sv/poisson_binomial_tail_update_top.sv =====
// Top level of the Poisson-binomial tail update block: sequencer, count and
// distribution memories, the shared update unit and the APB register.
// Depends on pbtu_pkg.
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+------------------
//  input    | in        | i_in_valid / o_in_stall        | i_in_data  (t_in_item)
//  output   | out       | o_out_valid / i_out_stall      | o_out_data (t_out_item)
//  config   | in        | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// The time from one transaction's acceptance to the next acceptance grows with
// trials, the image's count after the step; a new transaction is taken only
// once the last one is through. The time is set by the walk over the row in
// the distribution memory, one entry per cycle through its single port pair.
// Reset marks every image as never cleared and sets min_successes to 1; no
// clearing pass is needed. A stalled result waits in the output register while
// the next transaction is already taken and worked on.
module poisson_binomial_tail_update_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pbtu_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pbtu_pkg::t_out_item o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import pbtu_pkg::*;

    // Sequencer and configuration.
    t_state             r_state, n_state;
    logic [6:0]         r_min_succ;
    logic [IMAGES-1:0]  r_img_ready;

    // Latched transaction.
    logic               r_op;
    logic [7:0]         r_img;
    logic [Q_W-1:0]     r_p;

    // Walk parameters set up once per transaction.
    logic               r_init;
    logic [CNT_W-1:0]   r_cnt_old;
    logic [CNT_W-1:0]   r_last;
    logic [Q_W-1:0]     r_pe, r_qe;
    logic [DIST_AW-1:0] r_base;
    logic [CNT_W-1:0]   r_idx;

    // Update pipeline: stage B holds the read data, stage C the products.
    logic               r_b_vld, r_b_zero, r_b_one;
    logic [CNT_W-1:0]   r_b_idx;
    logic [Q_W-1:0]     r_rdata, r_prev;
    logic               r_c_vld;
    logic [CNT_W-1:0]   r_c_idx;
    logic [Q_W-1:0]     r_prod_p, r_prod_q;
    logic [Q_W-1:0]     r_tail;

    // Result of the transaction in flight and the output register.
    logic [CNT_W-1:0]   r_res_cnt;
    logic               r_res_full;
    logic               r_out_valid;
    t_out_item          r_out;

    // Memories.
    logic [CNT_W-1:0]   m_cnt [IMAGES];
    logic [CNT_W-1:0]   r_cnt_rd;
    logic [Q_W-1:0]     m_dist [IMAGES * ROW_LEN];

    // Strobes from the sequencer.
    logic               accept, setup, issue, load;

    // Setup decode.
    logic [IMG_AW-1:0]  img_idx;
    logic               img_ok, init, full, grow;
    logic [CNT_W-1:0]   cnt_old, new_cnt;
    logic [Q_W-1:0]     pe, p_in;

    // Datapath.
    logic               rd_en, cfg_wr;
    logic [Q_W-1:0]     cur, new_val;
    logic [2*Q_W-1:0]   mul_p, mul_q;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MIN_SUCC);
    assign prdata = (paddr[2] == REG_MIN_SUCC) ? {25'd0, r_min_succ} : 32'd0;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A probability above one is taken as one.
    assign p_in = (i_in_data.trial_prob > ONE_Q16) ? ONE_Q16 : i_in_data.trial_prob;

    // An image that was never cleared behaves as freshly cleared.
    assign img_idx = r_img[IMG_AW-1:0];
    assign img_ok  = (int'(r_img) < IMAGES);
    assign init    = (r_op == OP_CLEAR) || !r_img_ready[img_idx];
    assign cnt_old = init ? '0 : r_cnt_rd;
    assign full    = (r_op == OP_ADD) && (cnt_old == CNT_W'(MAX_TRIALS));
    assign grow    = (r_op == OP_ADD) && !full;
    assign new_cnt = grow ? cnt_old + 1'b1 : cnt_old;
    // A clear or a refused add walks the row with p = 0, which passes every
    // entry through unchanged and only forms the tail sum.
    assign pe      = grow ? r_p : '0;

    always_comb begin
        n_state = r_state;
        accept  = 1'b0;
        setup   = 1'b0;
        issue   = 1'b0;
        load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    accept  = 1'b1;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                setup   = 1'b1;
                n_state = img_ok ? S_WALK : S_DRAIN;
            end
            S_WALK: begin
                issue = 1'b1;
                if (r_idx == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_b_vld && !r_c_vld && (!r_out_valid || !i_out_stall)) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state that reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_succ  <= 7'd1;
            r_img_ready <= '0;
            r_b_vld     <= 1'b0;
            r_c_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_min_succ <= pwdata[6:0];
            end
            if (setup && img_ok) begin
                r_img_ready[img_idx] <= 1'b1;
            end
            r_b_vld <= issue;
            r_c_vld <= r_b_vld;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Entry read in stage B: forced to one for the first entry of a cleared
    // row, and to zero for the new top entry of an add.
    assign cur = r_b_one ? ONE_Q16 : (r_b_zero ? '0 : r_rdata);

    assign mul_p   = r_pe * r_prev;
    assign mul_q   = r_qe * cur;
    assign new_val = sat_add(r_prod_p, r_prod_q);

    assign rd_en = issue && (r_idx <= r_cnt_old);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_in_data.opcode;
            r_img <= i_in_data.image;
            r_p   <= p_in;
        end
        if (setup) begin
            r_init     <= init;
            r_cnt_old  <= cnt_old;
            r_last     <= new_cnt;
            r_pe       <= pe;
            r_qe       <= ONE_Q16 - pe;
            r_base     <= DIST_AW'(img_idx) * DIST_AW'(ROW_LEN);
            r_idx      <= '0;
            r_prev     <= '0;
            r_tail     <= '0;
            r_res_cnt  <= img_ok ? new_cnt : '0;
            r_res_full <= img_ok && full;
        end else if (issue) begin
            r_idx <= r_idx + 1'b1;
        end
        r_b_idx  <= r_idx;
        r_b_zero <= (r_idx > r_cnt_old);
        r_b_one  <= r_init && (r_idx == '0);
        if (r_b_vld) begin
            r_prev   <= cur;
            r_prod_p <= mul_p[Q_W+15:16];
            r_prod_q <= mul_q[Q_W+15:16];
            r_c_idx  <= r_b_idx;
        end
        if (r_c_vld && (32'(r_c_idx) >= 32'(r_min_succ))) begin
            r_tail <= sat_add(r_tail, new_val);
        end
        if (load) begin
            r_out.tail_prob <= r_tail;
            r_out.trials    <= 6'(r_res_cnt);
            r_out.full_res  <= r_res_full;
        end
    end

    // Trial count memory, read at acceptance and written back at setup.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cnt_rd <= m_cnt[i_in_data.image[IMG_AW-1:0]];
        end
        if (setup && img_ok) begin
            m_cnt[img_idx] <= new_cnt;
        end
    end

    // Distribution memory: stage A reads entry k while stage C writes entry
    // k - 2, so the two ports never meet on one address.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= m_dist[r_base + DIST_AW'(r_idx)];
        end
        if (r_c_vld) begin
            m_dist[r_base + DIST_AW'(r_c_idx)] <= new_val;
        end
    end

endmodule
